// ===== design/sha_pkg.sv =====
package sha_pkg;

  localparam int unsigned WordW  = 32;
  localparam int unsigned Rounds = 64;
  localparam int unsigned BlkWords = 16;
  localparam int unsigned HashWords = 8;
  localparam logic [7:0] PadMark = 8'h80;
  localparam logic [5:0] LenStart = 6'd56;

  typedef struct packed {
    logic app;         // append input byte
    logic pad;         // write padding byte
    logic pad_mark;    // padding byte is the 0x80 marker
    logic pad_len;     // length field goes into this block
    logic comp_start;  // load working vars from hash
    logic round;       // one compression round
    logic fold;        // add working vars into hash
    logic emit;        // load output register with next digest word
    logic restart;     // back to initial hash, clear fill and byte counters
  } cmd_t;

  typedef struct packed {
    logic fill_last;   // byte 63 of the block is next
    logic fill_low;    // fewer than 56 bytes held
    logic rnd_last;    // round 63 in progress
    logic emit_last;   // digest word 7 is next
    logic out_space;   // output register can take a beat
  } sts_t;

  function automatic logic [31:0] iv_word(input logic [2:0] idx);
    logic [31:0] r;
    case (idx)
      3'd0: r = 32'h6a09e667;
      3'd1: r = 32'hbb67ae85;
      3'd2: r = 32'h3c6ef372;
      3'd3: r = 32'ha54ff53a;
      3'd4: r = 32'h510e527f;
      3'd5: r = 32'h9b05688c;
      3'd6: r = 32'h1f83d9ab;
      default: r = 32'h5be0cd19;
    endcase
    return r;
  endfunction

  function automatic logic [31:0] round_k(input logic [5:0] idx);
    logic [31:0] r;
    case (idx)
      6'd0: r = 32'h428a2f98;  6'd1: r = 32'h71374491;
      6'd2: r = 32'hb5c0fbcf;  6'd3: r = 32'he9b5dba5;
      6'd4: r = 32'h3956c25b;  6'd5: r = 32'h59f111f1;
      6'd6: r = 32'h923f82a4;  6'd7: r = 32'hab1c5ed5;
      6'd8: r = 32'hd807aa98;  6'd9: r = 32'h12835b01;
      6'd10: r = 32'h243185be; 6'd11: r = 32'h550c7dc3;
      6'd12: r = 32'h72be5d74; 6'd13: r = 32'h80deb1fe;
      6'd14: r = 32'h9bdc06a7; 6'd15: r = 32'hc19bf174;
      6'd16: r = 32'he49b69c1; 6'd17: r = 32'hefbe4786;
      6'd18: r = 32'h0fc19dc6; 6'd19: r = 32'h240ca1cc;
      6'd20: r = 32'h2de92c6f; 6'd21: r = 32'h4a7484aa;
      6'd22: r = 32'h5cb0a9dc; 6'd23: r = 32'h76f988da;
      6'd24: r = 32'h983e5152; 6'd25: r = 32'ha831c66d;
      6'd26: r = 32'hb00327c8; 6'd27: r = 32'hbf597fc7;
      6'd28: r = 32'hc6e00bf3; 6'd29: r = 32'hd5a79147;
      6'd30: r = 32'h06ca6351; 6'd31: r = 32'h14292967;
      6'd32: r = 32'h27b70a85; 6'd33: r = 32'h2e1b2138;
      6'd34: r = 32'h4d2c6dfc; 6'd35: r = 32'h53380d13;
      6'd36: r = 32'h650a7354; 6'd37: r = 32'h766a0abb;
      6'd38: r = 32'h81c2c92e; 6'd39: r = 32'h92722c85;
      6'd40: r = 32'ha2bfe8a1; 6'd41: r = 32'ha81a664b;
      6'd42: r = 32'hc24b8b70; 6'd43: r = 32'hc76c51a3;
      6'd44: r = 32'hd192e819; 6'd45: r = 32'hd6990624;
      6'd46: r = 32'hf40e3585; 6'd47: r = 32'h106aa070;
      6'd48: r = 32'h19a4c116; 6'd49: r = 32'h1e376c08;
      6'd50: r = 32'h2748774c; 6'd51: r = 32'h34b0bcb5;
      6'd52: r = 32'h391c0cb3; 6'd53: r = 32'h4ed8aa4a;
      6'd54: r = 32'h5b9cca4f; 6'd55: r = 32'h682e6ff3;
      6'd56: r = 32'h748f82ee; 6'd57: r = 32'h78a5636f;
      6'd58: r = 32'h84c87814; 6'd59: r = 32'h8cc70208;
      6'd60: r = 32'h90befffa; 6'd61: r = 32'ha4506ceb;
      6'd62: r = 32'hbef9a3f7; default: r = 32'hc67178f2;
    endcase
    return r;
  endfunction

  function automatic logic [31:0] big_s0(input logic [31:0] x);
    return {x[1:0], x[31:2]} ^ {x[12:0], x[31:13]} ^ {x[21:0], x[31:22]};
  endfunction

  function automatic logic [31:0] big_s1(input logic [31:0] x);
    return {x[5:0], x[31:6]} ^ {x[10:0], x[31:11]} ^ {x[24:0], x[31:25]};
  endfunction

  function automatic logic [31:0] sml_s0(input logic [31:0] x);
    return {x[6:0], x[31:7]} ^ {x[17:0], x[31:18]} ^ {3'b000, x[31:3]};
  endfunction

  function automatic logic [31:0] sml_s1(input logic [31:0] x);
    return {x[16:0], x[31:17]} ^ {x[18:0], x[31:19]} ^ {10'd0, x[31:10]};
  endfunction

endpackage

// ===== design/sha_ifs.sv =====
interface sha_in_if;
  logic       valid;
  logic       ready;
  logic       mode;
  logic [7:0] data_byte;

  modport source (output valid, output mode, output data_byte, input ready);
  modport sink (input valid, input mode, input data_byte, output ready);
endinterface

interface sha_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] digest_word;
  logic [2:0]  word_index;
  logic        last_word;

  modport source (output valid, output digest_word, output word_index, output last_word,
                  input ready);
  modport sink (input valid, input digest_word, input word_index, input last_word,
                output ready);
endinterface

// ===== design/sha_ctrl.sv =====
module sha_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  input  logic          in_mode_i,
  output logic          in_ready_o,
  input  sha_pkg::sts_t sts_i,
  output sha_pkg::cmd_t cmd_o
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_PAD  = 3'd1;
  localparam logic [2:0] S_COMP = 3'd2;
  localparam logic [2:0] S_FIN  = 3'd3;
  localparam logic [2:0] S_EMIT = 3'd4;

  logic [2:0] state_q, state_d;
  logic [2:0] ret_q, ret_d;
  logic       first_q, first_d;
  logic       fin_q, fin_d;

  assign in_ready_o = (state_q == S_IDLE);

  always_comb begin
    state_d = state_q;
    ret_d   = ret_q;
    first_d = first_q;
    fin_d   = fin_q;
    cmd_o   = '0;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          if (!in_mode_i) begin
            cmd_o.app = 1'b1;
            if (sts_i.fill_last) begin
              cmd_o.comp_start = 1'b1;
              ret_d   = S_IDLE;
              state_d = S_COMP;
            end
          end else begin
            first_d = 1'b1;
            fin_d   = sts_i.fill_low;
            state_d = S_PAD;
          end
        end
      end
      S_PAD: begin
        cmd_o.pad      = 1'b1;
        cmd_o.pad_mark = first_q;
        cmd_o.pad_len  = fin_q;
        first_d        = 1'b0;
        if (sts_i.fill_last) begin
          cmd_o.comp_start = 1'b1;
          ret_d   = fin_q ? S_EMIT : S_PAD;
          fin_d   = 1'b1;
          state_d = S_COMP;
        end
      end
      S_COMP: begin
        cmd_o.round = 1'b1;
        if (sts_i.rnd_last) begin
          state_d = S_FIN;
        end
      end
      S_FIN: begin
        cmd_o.fold = 1'b1;
        state_d    = ret_q;
      end
      S_EMIT: begin
        if (sts_i.out_space) begin
          cmd_o.emit = 1'b1;
          if (sts_i.emit_last) begin
            cmd_o.restart = 1'b1;
            state_d       = S_IDLE;
          end
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      ret_q   <= S_IDLE;
      first_q <= 1'b0;
      fin_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      ret_q   <= ret_d;
      first_q <= first_d;
      fin_q   <= fin_d;
    end
  end

endmodule

// ===== design/sha_dp.sv =====
module sha_dp (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic [7:0]    data_byte_i,
  input  sha_pkg::cmd_t cmd_i,
  output sha_pkg::sts_t sts_o,
  input  logic          out_ready_i,
  output logic          out_valid_o,
  output logic [31:0]   digest_word_o,
  output logic [2:0]    word_index_o,
  output logic          last_word_o
);

  logic [31:0] win_q [sha_pkg::BlkWords];
  logic [31:0] v_q   [sha_pkg::HashWords];
  logic [31:0] h_q   [sha_pkg::HashWords];
  logic [5:0]  fill_q;
  logic [60:0] total_q;
  logic [5:0]  rnd_q;
  logic [2:0]  idx_q;
  logic        out_valid_q;
  logic [31:0] out_word_q;
  logic [2:0]  out_idx_q;
  logic        out_last_q;

  logic [63:0] len_bits;
  logic [5:0]  len_sh;
  logic [7:0]  len_byte;
  logic [7:0]  pad_byte;
  logic [7:0]  wr_byte;
  logic        wr_en;
  logic [31:0] w_next;
  logic [31:0] ch_v, maj_v, t1, t2;

  assign len_bits = {total_q, 3'b000};
  assign len_sh   = {3'd7 - fill_q[2:0], 3'b000};
  assign len_byte = 8'(len_bits >> len_sh);

  always_comb begin
    if (cmd_i.pad_mark) begin
      pad_byte = sha_pkg::PadMark;
    end else if (cmd_i.pad_len && (fill_q >= sha_pkg::LenStart)) begin
      pad_byte = len_byte;
    end else begin
      pad_byte = 8'h00;
    end
  end

  assign wr_en   = cmd_i.app | cmd_i.pad;
  assign wr_byte = cmd_i.app ? data_byte_i : pad_byte;

  assign w_next = win_q[0] + sha_pkg::sml_s0(win_q[1]) + win_q[9]
                + sha_pkg::sml_s1(win_q[14]);

  assign ch_v  = (v_q[4] & v_q[5]) ^ (~v_q[4] & v_q[6]);
  assign maj_v = (v_q[0] & v_q[1]) ^ (v_q[0] & v_q[2]) ^ (v_q[1] & v_q[2]);
  assign t1    = v_q[7] + sha_pkg::big_s1(v_q[4]) + ch_v + sha_pkg::round_k(rnd_q) + win_q[0];
  assign t2    = sha_pkg::big_s0(v_q[0]) + maj_v;

  // block window: bytes land here, then it slides as the message schedule
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      win_q[fill_q[5:2]][8*(3 - fill_q[1:0]) +: 8] <= wr_byte;
    end else if (cmd_i.round) begin
      for (int i = 0; i < sha_pkg::BlkWords - 1; i++) begin
        win_q[i] <= win_q[i+1];
      end
      win_q[sha_pkg::BlkWords-1] <= w_next;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.comp_start) begin
      for (int i = 0; i < sha_pkg::HashWords; i++) begin
        v_q[i] <= h_q[i];
      end
    end else if (cmd_i.round) begin
      v_q[7] <= v_q[6];
      v_q[6] <= v_q[5];
      v_q[5] <= v_q[4];
      v_q[4] <= v_q[3] + t1;
      v_q[3] <= v_q[2];
      v_q[2] <= v_q[1];
      v_q[1] <= v_q[0];
      v_q[0] <= t1 + t2;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < sha_pkg::HashWords; i++) begin
        h_q[i] <= sha_pkg::iv_word(3'(i));
      end
      fill_q  <= '0;
      total_q <= '0;
      rnd_q   <= '0;
      idx_q   <= '0;
    end else begin
      if (cmd_i.restart) begin
        for (int i = 0; i < sha_pkg::HashWords; i++) begin
          h_q[i] <= sha_pkg::iv_word(3'(i));
        end
        fill_q  <= '0;
        total_q <= '0;
      end else begin
        if (cmd_i.fold) begin
          for (int i = 0; i < sha_pkg::HashWords; i++) begin
            h_q[i] <= h_q[i] + v_q[i];
          end
        end
        if (wr_en) begin
          fill_q <= fill_q + 6'd1;
        end
        if (cmd_i.app) begin
          total_q <= total_q + 61'd1;
        end
      end
      if (cmd_i.round) begin
        rnd_q <= rnd_q + 6'd1;
      end
      if (cmd_i.emit) begin
        idx_q <= idx_q + 3'd1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.emit) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      out_word_q <= h_q[idx_q];
      out_idx_q  <= idx_q;
      out_last_q <= (idx_q == 3'd7);
    end
  end

  assign sts_o.fill_last = (fill_q == 6'd63);
  assign sts_o.fill_low  = (fill_q < sha_pkg::LenStart);
  assign sts_o.rnd_last  = (rnd_q == 6'(sha_pkg::Rounds - 1));
  assign sts_o.emit_last = (idx_q == 3'd7);
  assign sts_o.out_space = !out_valid_q || out_ready_i;

  assign out_valid_o   = out_valid_q;
  assign digest_word_o = out_word_q;
  assign word_index_o  = out_idx_q;
  assign last_word_o   = out_last_q;

endmodule

// ===== design/sha256_stream_hasher.sv =====
// channel | dir | payload                               | beat
// in_i    | in  | mode, data_byte                       | one message byte or a close
// out_o   | out | digest_word, word_index, last_word    | one digest word, 8 per close
//
// Append beat: the 64th byte of a block starts a compression of 64 rounds on the
// single round unit and one fold. Close: one cycle per padding byte up to byte 63,
// then compression of each padded block (one or two), then 8 output beats.
// rst_ni is asynchronous; after reset the hash is at its initial value, no bytes held.
// in_i.ready is low while a block compresses, pads or the digest drains; out_o stalls
// hold the digest sequence in place.
module sha256_stream_hasher (
  input  logic      clk_i,
  input  logic      rst_ni,
  sha_in_if.sink    in_i,
  sha_out_if.source out_o
);

  sha_pkg::cmd_t cmd;
  sha_pkg::sts_t sts;

  sha_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_mode_i  (in_i.mode),
    .in_ready_o (in_i.ready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  sha_dp u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .data_byte_i   (in_i.data_byte),
    .cmd_i         (cmd),
    .sts_o         (sts),
    .out_ready_i   (out_o.ready),
    .out_valid_o   (out_o.valid),
    .digest_word_o (out_o.digest_word),
    .word_index_o  (out_o.word_index),
    .last_word_o   (out_o.last_word)
  );

endmodule

// ===== tb/tb_sha256_stream_hasher.sv =====
`timescale 1ns / 1ps

module tb_sha256_stream_hasher;

  localparam bit ModeAppend = 1'b0;
  localparam bit ModeClose  = 1'b1;

  localparam bit [31:0] HashInit [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19};

  localparam bit [31:0] RoundConst [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2};

  typedef struct {
    bit [31:0] word;
    bit [2:0]  idx;
    bit        is_last;
  } digest_beat_t;

  class digest_scoreboard;
    bit [31:0] hash_st [8];
    bit [7:0]  blk [64];
    bit [5:0]  fill;
    bit [60:0] nbytes;
    digest_beat_t due [$];
    int errors;

    function new();
      int i;
      for (i = 0; i < 64; i++) blk[i] = 8'h00;
      errors = 0;
      restart();
    endfunction

    function void restart();
      hash_st = HashInit;
      fill = 6'd0;
      nbytes = 61'd0;
    endfunction

    function bit [31:0] ror(bit [31:0] x, int n);
      return (x >> n) | (x << (32 - n));
    endfunction

    function void compress();
      bit [31:0] w [64];
      bit [31:0] v [8];
      bit [31:0] s0, s1, t1, t2, chv, majv;
      int t;
      for (t = 0; t < 16; t++)
        w[t] = {blk[4 * t], blk[4 * t + 1], blk[4 * t + 2], blk[4 * t + 3]};
      for (t = 16; t < 64; t++) begin
        s0 = ror(w[t - 15], 7) ^ ror(w[t - 15], 18) ^ (w[t - 15] >> 3);
        s1 = ror(w[t - 2], 17) ^ ror(w[t - 2], 19) ^ (w[t - 2] >> 10);
        w[t] = w[t - 16] + s0 + w[t - 7] + s1;
      end
      v = hash_st;
      for (t = 0; t < 64; t++) begin
        s1 = ror(v[4], 6) ^ ror(v[4], 11) ^ ror(v[4], 25);
        chv = (v[4] & v[5]) ^ (~v[4] & v[6]);
        t1 = v[7] + s1 + chv + RoundConst[t] + w[t];
        s0 = ror(v[0], 2) ^ ror(v[0], 13) ^ ror(v[0], 22);
        majv = (v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]);
        t2 = s0 + majv;
        v[7] = v[6];
        v[6] = v[5];
        v[5] = v[4];
        v[4] = v[3] + t1;
        v[3] = v[2];
        v[2] = v[1];
        v[1] = v[0];
        v[0] = t1 + t2;
      end
      for (t = 0; t < 8; t++) hash_st[t] = hash_st[t] + v[t];
    endfunction

    function void note_beat(bit mode, bit [7:0] b);
      int pos;
      int i;
      bit [63:0] bits;
      digest_beat_t db;
      if (mode == ModeAppend) begin
        blk[fill] = b;
        nbytes = nbytes + 61'd1;
        fill = fill + 6'd1;
        if (fill == 6'd0) compress();
        return;
      end
      pos = fill;
      blk[pos] = 8'h80;
      pos++;
      if (pos > 56) begin
        while (pos < 64) begin
          blk[pos] = 8'h00;
          pos++;
        end
        compress();
        pos = 0;
      end
      while (pos < 56) begin
        blk[pos] = 8'h00;
        pos++;
      end
      bits = {nbytes, 3'b000};
      for (i = 0; i < 8; i++) blk[56 + i] = bits[63 - 8 * i -: 8];
      compress();
      for (i = 0; i < 8; i++) begin
        db.word = hash_st[i];
        db.idx = i[2:0];
        db.is_last = (i == 7);
        due.push_back(db);
      end
      restart();
    endfunction

    function void check_word(bit [31:0] w, bit [2:0] idx, bit is_last);
      digest_beat_t exp_b;
      if (due.size() == 0) begin
        $error("unexpected digest beat: digest_word %h word_index %0d", w, idx);
        errors++;
        return;
      end
      exp_b = due.pop_front();
      if (exp_b.word != w) begin
        $error("digest_word: expected %h, got %h", exp_b.word, w);
        errors++;
      end
      if (exp_b.idx != idx) begin
        $error("word_index: expected %0d, got %0d", exp_b.idx, idx);
        errors++;
      end
      if (exp_b.is_last != is_last) begin
        $error("last_word: expected %0b, got %0b", exp_b.is_last, is_last);
        errors++;
      end
    endfunction

    function int pending();
      return due.size();
    endfunction
  endclass

  logic clk_i;
  logic rst_ni;

  sha_in_if  in_if ();
  sha_out_if out_if ();

  sha256_stream_hasher dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if)
  );

  digest_scoreboard sb = new();

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  task automatic send_beat(input bit mode, input bit [7:0] b, input bit calm);
    int gap;
    gap = calm ? 0 : pick_gap();
    if (gap > 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_if.valid     <= 1'b1;
    in_if.mode      <= mode;
    in_if.data_byte <= b;
    do @(posedge clk_i); while (!in_if.ready);
    sb.note_beat(mode, b);
  endtask

  task automatic send_message(input int len, input bit calm);
    int i;
    for (i = 0; i < len; i++) send_beat(ModeAppend, 8'($urandom_range(0, 255)), calm);
    send_beat(ModeClose, 8'($urandom_range(0, 255)), calm);
  endtask

  initial begin
    int n_rand;
    int msg_no;
    int len;
    int r;
    rst_ni          <= 1'b0;
    in_if.valid     <= 1'b0;
    in_if.mode      <= ModeAppend;
    in_if.data_byte <= 8'h00;
    out_if.ready    <= 1'b0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // empty message, then close with a set data byte that must be ignored
    send_beat(ModeClose, 8'h00, 1'b0);
    send_beat(ModeClose, 8'hff, 1'b0);
    send_beat(ModeAppend, 8'h61, 1'b1);
    send_beat(ModeAppend, 8'h62, 1'b1);
    send_beat(ModeAppend, 8'h63, 1'b1);
    send_beat(ModeClose, 8'h00, 1'b1);
    send_beat(ModeAppend, 8'hff, 1'b0);
    send_beat(ModeClose, 8'hff, 1'b0);
    send_beat(ModeAppend, 8'h00, 1'b0);
    send_beat(ModeClose, 8'h00, 1'b0);

    n_rand = 0;
    msg_no = 0;
    while (n_rand < 260) begin
      case (msg_no)
        0: len = 56 + $urandom_range(0, 7);  // padding spills into a second block
        1: len = 64;                         // exactly one full block
        default: begin
          r = $urandom_range(0, 9);
          if (r < 3) len = $urandom_range(0, 6);
          else if (r < 6) len = $urandom_range(40, 63);
          else if (r < 8) len = $urandom_range(60, 70);
          else if (r < 9) len = $urandom_range(100, 140);
          else len = 0;
        end
      endcase
      send_message(len, $urandom_range(0, 3) == 0);
      n_rand += len + 1;
      msg_no++;
    end
    in_if.valid <= 1'b0;

    while (sb.pending() != 0) @(posedge clk_i);
    repeat (200) @(posedge clk_i);
    if (sb.errors == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  initial begin
    int hold_left;
    int calm_left;
    int got;
    bit long_done;
    bit rdy;
    hold_left = 0;
    calm_left = 0;
    got = 0;
    long_done = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (out_if.valid && out_if.ready) begin
        sb.check_word(out_if.digest_word, out_if.word_index, out_if.last_word);
        got++;
      end
      rdy = 1'b1;
      if (hold_left > 0) begin
        hold_left--;
        rdy = 1'b0;
      end else if (!long_done && got >= 16) begin
        // long back-pressure so the input side stalls behind a full output
        long_done = 1'b1;
        hold_left = 399;
        rdy = 1'b0;
      end else if (calm_left > 0) begin
        calm_left--;
      end else if ($urandom_range(0, 15) == 0) begin
        calm_left = $urandom_range(20, 80);
      end else begin
        hold_left = pick_gap();
        if (hold_left > 0) begin
          hold_left--;
          rdy = 1'b0;
        end
      end
      out_if.ready <= rdy;
    end
  end

  initial begin
    #40_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
